// File: src/boundary_tag_heap_allocator_macros.svh
// -----------------------------------------------------------------------------
// Boundary-tag heap allocator: assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// -----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define BTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/bta_pkg.sv
// -----------------------------------------------------------------------------
// bta_pkg
// Shared constants, types and helpers of the boundary-tag heap allocator.
// -----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned HEAP_WORDS = 4096;
  localparam int unsigned ADDR_W     = $clog2(HEAP_WORDS);
  localparam int unsigned HEAP_BYTES = HEAP_WORDS * 4;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned END_W      = $clog2(HEAP_BYTES) + 1;
  // internal byte offsets: heap end plus one tag's reach
  localparam int unsigned OFF_W      = END_W + 2;
  localparam int unsigned CLR_W      = ADDR_W + 1;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CFG_W  = 15;
  localparam int unsigned REQ_W  = 15;
  localparam int unsigned FOFF_W = 14;
  localparam int unsigned PAY_W  = 14;

  localparam logic [CFG_W-1:0] HEAP_SIZE_RST = CFG_W'(16384);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_BOOT_H, S_BOOT_T, S_IDLE, S_FMT_H, S_FMT_T,
    S_A_CHECK, S_A_TAG, S_A_P1H, S_A_P1T, S_A_P2H, S_A_P2T,
    S_F_CHECK, S_F_TAG, S_F_PH, S_F_PT, S_F_PREV, S_F_MPH, S_F_MPT,
    S_F_NCHK, S_F_NEXT, S_F_MNH, S_F_MNT, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_CLR, MEM_RD_POS, MEM_RD_PREV, MEM_RD_NEXT, MEM_WR_HEAD, MEM_WR_TAIL,
    MEM_WR_TAIL_RD_PREV
  } mem_e;

  typedef enum logic [3:0] {
    LD_NONE, LD_BOOT, LD_FMT, LD_ALLOC, LD_FREE, LD_RSVD, LD_A_STEP,
    LD_A_FIT, LD_A_SPLIT, LD_F_BLK, LD_F_PREV, LD_F_NEXT
  } ld_e;

  typedef struct packed {
    mem_e mem;
    ld_e  ld;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pos_ge_end;
    logic null_off;
    logic tag_zero;
    logic a_fit;
    logic a_split;
    logic f_bad;
    logic p_ge4;
    logic prev_merge;
    logic next_in;
    logic next_merge;
    logic out_free;
  } dp_stat_t;

  // Clear the low two bits, raise to 16 bytes, limit to the store.
  function automatic logic [END_W-1:0] eff_size(input logic [CFG_W-1:0] hs);
    logic [CFG_W-1:0] e;
    e = hs & ~CFG_W'(3);
    if (e < CFG_W'(16)) e = CFG_W'(16);
    if (32'(e) > HEAP_BYTES) e = CFG_W'(HEAP_BYTES);
    return END_W'(e);
  endfunction

  // True when a byte offset falls inside the word store.
  function automatic logic in_store(input logic [OFF_W-1:0] off);
    return (off >> (ADDR_W + 2)) == '0;
  endfunction

  localparam logic [END_W-1:0] HEAP_END_RST = eff_size(HEAP_SIZE_RST);

endpackage

// File: src/boundary_tag_heap_allocator.sv
// -----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First-fit heap allocator over a tagged word store, one command at a time.
// -----------------------------------------------------------------------------
// Commands arrive on the s_axis channel: tuser carries the command (init,
// allocate, free), tdata the request size and the offset to free. Every
// accepted word gives exactly one result word on m_axis: the payload offset
// in tdata and the success flag in tuser.
// The allocate walk reads the tags one by one from the single read port of the
// store, and each put of a block writes its head tag and then its tail tag
// on the write port.
// The next command is taken once the result has moved into the output
// register, so a stalled receiver holds one result and the command after it.
// At reset the whole store is swept to zero, one word a cycle,
// then formatted as one free block of the reset heap size; s_axis_tready stays
// low until this is done. heap_size may be written at any time, and takes
// effect only at the next init.
// -----------------------------------------------------------------------------
module boundary_tag_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: heap size in bytes
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  // command words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [14:0] request_size, [28:15] free_offset, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [13:0] payload_offset, rest zero
  output logic        m_axis_tuser   // [0] success
);

  bta_pkg::ctl_cmd_t           cmd;
  bta_pkg::dp_stat_t           stat;
  logic [bta_pkg::PAY_W-1:0]   pay;

  // sequencer: owns the input handshake and drives the datapath
  bta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: store, arithmetic and the output register
  bta_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (s_axis_tdata[14:0]),
    .foff_i      (s_axis_tdata[28:15]),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .pay_o       (pay),
    .ok_o        (m_axis_tuser)
  );

  // pad the offset to a whole number of bytes
  assign m_axis_tdata = {2'b00, pay};

endmodule

// File: src/bta_ram.sv
// -----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module bta_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bta_ctrl.sv
// -----------------------------------------------------------------------------
// bta_ctrl
// Command sequencer: walks boot, init, allocate, free and reserved words through the datapath.
// -----------------------------------------------------------------------------
`include "boundary_tag_heap_allocator_macros.svh"

module bta_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [bta_pkg::CMD_W-1:0]    in_cmd_i,
  output logic                         in_ready_o,
  input  bta_pkg::dp_stat_t            stat_i,
  output bta_pkg::ctl_cmd_t            cmd_o
);

  bta_pkg::state_e state_q, state_d;
  bta_pkg::cmd_e   cmd_in;

  assign cmd_in     = bta_pkg::cmd_e'(in_cmd_i);
  assign in_ready_o = (state_q == bta_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bta_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bta_pkg::S_CLEAR:   if (stat_i.clr_done) state_d = bta_pkg::S_BOOT_H;
      bta_pkg::S_BOOT_H:  state_d = bta_pkg::S_BOOT_T;
      bta_pkg::S_BOOT_T:  state_d = bta_pkg::S_IDLE;
      bta_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_in)
            bta_pkg::CMD_INIT:  state_d = bta_pkg::S_FMT_H;
            bta_pkg::CMD_ALLOC: state_d = bta_pkg::S_A_CHECK;
            bta_pkg::CMD_FREE:  state_d = bta_pkg::S_F_CHECK;
            default:            state_d = bta_pkg::S_DONE;
          endcase
        end
      end
      bta_pkg::S_FMT_H:   state_d = bta_pkg::S_FMT_T;
      bta_pkg::S_FMT_T:   state_d = bta_pkg::S_DONE;
      bta_pkg::S_A_CHECK: state_d = stat_i.pos_ge_end ? bta_pkg::S_DONE : bta_pkg::S_A_TAG;
      bta_pkg::S_A_TAG: begin
        if (stat_i.tag_zero)   state_d = bta_pkg::S_DONE;
        else if (stat_i.a_fit) state_d = bta_pkg::S_A_P1H;
        else                   state_d = bta_pkg::S_A_CHECK;
      end
      bta_pkg::S_A_P1H:   state_d = bta_pkg::S_A_P1T;
      bta_pkg::S_A_P1T:   state_d = stat_i.a_split ? bta_pkg::S_A_P2H : bta_pkg::S_DONE;
      bta_pkg::S_A_P2H:   state_d = bta_pkg::S_A_P2T;
      bta_pkg::S_A_P2T:   state_d = bta_pkg::S_DONE;
      bta_pkg::S_F_CHECK: begin
        state_d = (stat_i.null_off || stat_i.pos_ge_end) ? bta_pkg::S_DONE
                                                          : bta_pkg::S_F_TAG;
      end
      bta_pkg::S_F_TAG:   state_d = stat_i.f_bad ? bta_pkg::S_DONE : bta_pkg::S_F_PH;
      bta_pkg::S_F_PH:    state_d = bta_pkg::S_F_PT;
      bta_pkg::S_F_PT:    state_d = stat_i.p_ge4 ? bta_pkg::S_F_PREV : bta_pkg::S_F_NCHK;
      bta_pkg::S_F_PREV: begin
        state_d = stat_i.prev_merge ? bta_pkg::S_F_MPH : bta_pkg::S_F_NCHK;
      end
      bta_pkg::S_F_MPH:   state_d = bta_pkg::S_F_MPT;
      bta_pkg::S_F_MPT:   state_d = bta_pkg::S_F_NCHK;
      bta_pkg::S_F_NCHK:  state_d = stat_i.next_in ? bta_pkg::S_F_NEXT : bta_pkg::S_DONE;
      bta_pkg::S_F_NEXT:  state_d = stat_i.next_merge ? bta_pkg::S_F_MNH : bta_pkg::S_DONE;
      bta_pkg::S_F_MNH:   state_d = bta_pkg::S_F_MNT;
      bta_pkg::S_F_MNT:   state_d = bta_pkg::S_DONE;
      bta_pkg::S_DONE:    if (stat_i.out_free) state_d = bta_pkg::S_IDLE;
      default:            state_d = bta_pkg::S_CLEAR;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '{mem: bta_pkg::MEM_NONE, ld: bta_pkg::LD_NONE, out_load: 1'b0};
    case (state_q)
      bta_pkg::S_CLEAR: begin
        if (stat_i.clr_done) cmd_o.ld  = bta_pkg::LD_BOOT;
        else                 cmd_o.mem = bta_pkg::MEM_CLR;
      end
      bta_pkg::S_BOOT_H, bta_pkg::S_FMT_H, bta_pkg::S_A_P1H, bta_pkg::S_A_P2H,
      bta_pkg::S_F_PH, bta_pkg::S_F_MPH, bta_pkg::S_F_MNH: begin
        cmd_o.mem = bta_pkg::MEM_WR_HEAD;
      end
      bta_pkg::S_BOOT_T, bta_pkg::S_FMT_T, bta_pkg::S_A_P2T,
      bta_pkg::S_F_MPT, bta_pkg::S_F_MNT: begin
        cmd_o.mem = bta_pkg::MEM_WR_TAIL;
      end
      bta_pkg::S_A_P1T: begin
        cmd_o.mem = bta_pkg::MEM_WR_TAIL;
        if (stat_i.a_split) cmd_o.ld = bta_pkg::LD_A_SPLIT;
      end
      bta_pkg::S_F_PT: begin
        // previous block's tail lies below the head, apart from the tail written now
        if (stat_i.p_ge4) cmd_o.mem = bta_pkg::MEM_WR_TAIL_RD_PREV;
        else              cmd_o.mem = bta_pkg::MEM_WR_TAIL;
      end
      bta_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_in)
            bta_pkg::CMD_INIT:  cmd_o.ld = bta_pkg::LD_FMT;
            bta_pkg::CMD_ALLOC: cmd_o.ld = bta_pkg::LD_ALLOC;
            bta_pkg::CMD_FREE:  cmd_o.ld = bta_pkg::LD_FREE;
            default:            cmd_o.ld = bta_pkg::LD_RSVD;
          endcase
        end
      end
      bta_pkg::S_A_CHECK: if (!stat_i.pos_ge_end) cmd_o.mem = bta_pkg::MEM_RD_POS;
      bta_pkg::S_A_TAG: begin
        if (!stat_i.tag_zero) begin
          cmd_o.ld = stat_i.a_fit ? bta_pkg::LD_A_FIT : bta_pkg::LD_A_STEP;
        end
      end
      bta_pkg::S_F_CHECK: begin
        if (!(stat_i.null_off || stat_i.pos_ge_end)) cmd_o.mem = bta_pkg::MEM_RD_POS;
      end
      bta_pkg::S_F_TAG:  if (!stat_i.f_bad) cmd_o.ld = bta_pkg::LD_F_BLK;
      bta_pkg::S_F_PREV: if (stat_i.prev_merge) cmd_o.ld = bta_pkg::LD_F_PREV;
      bta_pkg::S_F_NCHK: if (stat_i.next_in) cmd_o.mem = bta_pkg::MEM_RD_NEXT;
      bta_pkg::S_F_NEXT: if (stat_i.next_merge) cmd_o.ld = bta_pkg::LD_F_NEXT;
      bta_pkg::S_DONE:   cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  `BTA_ASSERT_IMP(a_tag_after_read, clk_i, rst_ni, state_q == bta_pkg::S_A_TAG, $past(state_q) == bta_pkg::S_A_CHECK, "allocate tag check without a preceding read")
  `BTA_ASSERT_IMP(a_out_slot_free, clk_i, rst_ni, cmd_o.out_load, stat_i.out_free, "result loaded over a waiting word")
  `BTA_ASSERT_IMP(a_idle_no_mem, clk_i, rst_ni, in_ready_o, cmd_o.mem == bta_pkg::MEM_NONE, "store access while taking a word")

endmodule

// File: src/bta_dp.sv
// -----------------------------------------------------------------------------
// bta_dp
// Heap datapath: tag store, walk and merge arithmetic, result register.
// -----------------------------------------------------------------------------
`include "boundary_tag_heap_allocator_macros.svh"

module bta_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bta_pkg::ctl_cmd_t             cmd_i,
  output bta_pkg::dp_stat_t             stat_o,
  input  logic                          cfg_we_i,
  input  logic [bta_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [bta_pkg::REQ_W-1:0]     req_i,
  input  logic [bta_pkg::FOFF_W-1:0]    foff_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [bta_pkg::PAY_W-1:0]     pay_o,
  output logic                          ok_o
);

  localparam int unsigned OW = bta_pkg::OFF_W;
  localparam int unsigned AW = bta_pkg::ADDR_W;

  // control state
  logic [bta_pkg::CFG_W-1:0] heap_size_q;
  logic [bta_pkg::END_W-1:0] heap_end_q;
  logic [bta_pkg::CLR_W-1:0] clr_cnt_q;
  logic                      m_valid_q;

  // working registers
  logic [OW-1:0]             pos_q, size_q, need_q, wr_pos_q, wr_size_q;
  logic                      wr_used_q, null_q, ok_q, ok_out_q;
  logic [bta_pkg::PAY_W-1:0] pay_q, pay_out_q;

  logic [bta_pkg::TAG_W-1:0] rtag, wdata;
  logic                      rused, ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [OW-1:0]             bsize, end_ext, pos_bsize, need_p8, next_off, next_end;
  logic [OW-1:0]             tail_off, prev_off, need_new, foff_al;
  logic [bta_pkg::END_W-1:0] fmt_end;

  assign bsize     = OW'({rtag[bta_pkg::TAG_W-1:2], 2'b00});
  assign rused     = rtag[0];
  assign end_ext   = OW'(heap_end_q);
  assign pos_bsize = pos_q + bsize;
  assign need_p8   = need_q + OW'(8);
  assign next_off  = pos_q + size_q;
  assign next_end  = next_off + bsize;
  assign tail_off  = wr_pos_q + wr_size_q - OW'(4);
  assign prev_off  = pos_q - OW'(4);
  assign need_new  = ((OW'(req_i) + OW'(3)) & ~OW'(3)) + OW'(8);
  assign foff_al   = OW'({foff_i[bta_pkg::FOFF_W-1:2], 2'b00});
  assign fmt_end   = bta_pkg::eff_size(heap_size_q);
  assign wdata     = wr_size_q[bta_pkg::TAG_W-1:0] | bta_pkg::TAG_W'(wr_used_q);

  // store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_pos_q[AW+1:2];
    ram_re    = 1'b0;
    ram_raddr = pos_q[AW+1:2];
    case (cmd_i.mem)
      bta_pkg::MEM_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q[AW-1:0];
      end
      bta_pkg::MEM_WR_HEAD: ram_we = bta_pkg::in_store(wr_pos_q);
      bta_pkg::MEM_WR_TAIL: begin
        ram_we    = bta_pkg::in_store(tail_off);
        ram_waddr = tail_off[AW+1:2];
      end
      bta_pkg::MEM_WR_TAIL_RD_PREV: begin
        // write the tail and fetch the previous block's tail together
        ram_we    = bta_pkg::in_store(tail_off);
        ram_waddr = tail_off[AW+1:2];
        ram_re    = 1'b1;
        ram_raddr = prev_off[AW+1:2];
      end
      bta_pkg::MEM_RD_POS:  ram_re = 1'b1;
      bta_pkg::MEM_RD_PREV: begin
        ram_re    = 1'b1;
        ram_raddr = prev_off[AW+1:2];
      end
      bta_pkg::MEM_RD_NEXT: begin
        ram_re    = 1'b1;
        ram_raddr = next_off[AW+1:2];
      end
      default: ;
    endcase
  end

  bta_ram #(
    .WIDTH(bta_pkg::TAG_W),
    .DEPTH(bta_pkg::HEAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ((cmd_i.mem == bta_pkg::MEM_CLR) ? '0 : wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rtag)
  );

  // status towards the sequencer
  assign stat_o.clr_done   = clr_cnt_q[AW];
  assign stat_o.pos_ge_end = pos_q >= end_ext;
  assign stat_o.null_off   = null_q;
  assign stat_o.tag_zero   = bsize == '0;
  assign stat_o.a_fit      = !rused && (bsize >= need_q) && (pos_bsize <= end_ext);
  assign stat_o.a_split    = size_q >= need_p8;
  assign stat_o.f_bad      = (bsize == '0) || (pos_bsize > end_ext);
  assign stat_o.p_ge4      = pos_q >= OW'(4);
  assign stat_o.prev_merge = !rused && (bsize != '0) && (bsize <= pos_q);
  assign stat_o.next_in    = next_off < end_ext;
  assign stat_o.next_merge = !rused && (bsize != '0) && (next_end <= end_ext);
  assign stat_o.out_free   = !m_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_size_q <= bta_pkg::HEAP_SIZE_RST;
      heap_end_q  <= bta_pkg::HEAP_END_RST;
      clr_cnt_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) heap_size_q <= cfg_wdata_i;
      if (cmd_i.ld == bta_pkg::LD_FMT) heap_end_q <= fmt_end;
      if (cmd_i.mem == bta_pkg::MEM_CLR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.out_load)  m_valid_q <= 1'b1;
      else if (m_ready_i)  m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pay_out_q <= pay_q;
      ok_out_q  <= ok_q;
    end
    case (cmd_i.ld)
      bta_pkg::LD_BOOT: begin
        wr_pos_q  <= '0;
        wr_size_q <= end_ext;
        wr_used_q <= 1'b0;
      end
      bta_pkg::LD_FMT: begin
        wr_pos_q  <= '0;
        wr_size_q <= OW'(fmt_end);
        wr_used_q <= 1'b0;
        ok_q      <= 1'b1;
        pay_q     <= '0;
      end
      bta_pkg::LD_ALLOC: begin
        need_q <= need_new;
        pos_q  <= '0;
        ok_q   <= 1'b0;
        pay_q  <= '0;
      end
      bta_pkg::LD_FREE: begin
        pos_q  <= foff_al - OW'(4);
        null_q <= foff_al == '0;
        ok_q   <= 1'b1;
        pay_q  <= '0;
      end
      bta_pkg::LD_RSVD: begin
        ok_q  <= 1'b0;
        pay_q <= '0;
      end
      bta_pkg::LD_A_STEP: pos_q <= pos_bsize;
      bta_pkg::LD_A_FIT: begin
        // split off the rest only when a whole tagged block still fits
        wr_pos_q  <= pos_q;
        wr_size_q <= (bsize >= need_p8) ? need_q : bsize;
        wr_used_q <= 1'b1;
        size_q    <= bsize;
        ok_q      <= 1'b1;
        pay_q     <= bta_pkg::PAY_W'(pos_q + OW'(4));
      end
      bta_pkg::LD_A_SPLIT: begin
        wr_pos_q  <= pos_q + need_q;
        wr_size_q <= size_q - need_q;
        wr_used_q <= 1'b0;
      end
      bta_pkg::LD_F_BLK: begin
        size_q    <= bsize;
        wr_pos_q  <= pos_q;
        wr_size_q <= bsize;
        wr_used_q <= 1'b0;
      end
      bta_pkg::LD_F_PREV: begin
        pos_q     <= pos_q - bsize;
        size_q    <= size_q + bsize;
        wr_pos_q  <= pos_q - bsize;
        wr_size_q <= size_q + bsize;
        wr_used_q <= 1'b0;
      end
      bta_pkg::LD_F_NEXT: begin
        // next merge starts from the block already merged with its predecessor
        wr_pos_q  <= pos_q;
        wr_size_q <= size_q + bsize;
        wr_used_q <= 1'b0;
      end
      default: ;
    endcase
  end

  assign m_valid_o = m_valid_q;
  assign pay_o     = pay_out_q;
  assign ok_o      = ok_out_q;

  `BTA_ASSERT_IMP(a_wr_size_nz, clk_i, rst_ni, (cmd_i.mem == bta_pkg::MEM_WR_HEAD) || (cmd_i.mem == bta_pkg::MEM_WR_TAIL), wr_size_q != '0, "tag write of a zero-size block")
  `BTA_ASSERT_NEXT(a_clr_hold, clk_i, rst_ni, stat_o.clr_done, stat_o.clr_done, "clearing sweep restarted")

endmodule

// File: tb/boundary_tag_heap_allocator_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Heap allocator checker
// Watches the command and result channels of the allocator, keeps its own
// copy of the tagged heap and the heap size register, works out the outcome
// of every accepted command word and compares it with the result words in
// order.
// -----------------------------------------------------------------------------
module boundary_tag_heap_allocator_checker
  import bta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [14:0] request_size, [28:15] free_offset, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // [13:0] payload_offset, rest zero
  input  logic        m_axis_tuser,  // [0] success
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    logic [PAY_W-1:0] offset;
    logic             ok;
  } outcome_t;

  logic [TAG_W-1:0] tag_store [HEAP_WORDS];
  logic [CFG_W-1:0] size_shadow;
  int unsigned      heap_limit;
  outcome_t         outcome_q [$];
  int               mismatch_total = 0;

  function automatic int unsigned read_tag(input int unsigned off);
    if ((off >> 2) < HEAP_WORDS) return tag_store[off >> 2];
    return 0;
  endfunction

  function automatic void write_tag(input int unsigned off, input int unsigned v);
    if ((off >> 2) < HEAP_WORDS) tag_store[off >> 2] = v[15:0];
  endfunction

  // Head and tail tag of one block.
  function automatic void place_block(input int unsigned at, input int unsigned size,
                                      input bit used);
    write_tag(at, size | used);
    write_tag(at + size - 4, size | used);
  endfunction

  function automatic void format_heap();
    int unsigned e;
    e = size_shadow & 15'h7FFC;
    if (e < 16) e = 16;
    if (e > HEAP_BYTES) e = HEAP_BYTES;
    heap_limit = e;
    place_block(0, e, 1'b0);
  endfunction

  function automatic int unsigned try_alloc(input int unsigned req);
    int unsigned need, pos, t, bsize;
    need = ((req + 3) & ~32'd3) + 8;
    pos  = 0;
    while (pos < heap_limit) begin
      t     = read_tag(pos);
      bsize = t & 32'hFFFC;
      if (bsize == 0) return 0;
      if (!t[0] && bsize >= need && pos + bsize <= heap_limit) begin
        if (bsize >= need + 8) begin
          place_block(pos, need, 1'b1);
          place_block(pos + need, bsize - need, 1'b0);
        end else begin
          place_block(pos, bsize, 1'b1);
        end
        return pos + 4;
      end
      pos += bsize;
    end
    return 0;
  endfunction

  function automatic void release_block(input int unsigned off_in);
    int unsigned off, p, size, t, ps, nxt, ns;
    off = off_in & ~32'd3;
    if (off == 0) return;
    p = off - 4;
    if (p >= heap_limit) return;
    size = read_tag(p) & 32'hFFFC;
    if (size == 0 || p + size > heap_limit) return;
    place_block(p, size, 1'b0);
    // merge backwards first, then forwards from the merged block
    if (p >= 4) begin
      t  = read_tag(p - 4);
      ps = t & 32'hFFFC;
      if (!t[0] && ps != 0 && ps <= p) begin
        p    -= ps;
        size += ps;
        place_block(p, size, 1'b0);
      end
    end
    nxt = p + size;
    if (nxt < heap_limit) begin
      t  = read_tag(nxt);
      ns = t & 32'hFFFC;
      if (!t[0] && ns != 0 && nxt + ns <= heap_limit) place_block(p, size + ns, 1'b0);
    end
  endfunction

  function automatic outcome_t predict_outcome(input cmd_e cmd, input logic [REQ_W-1:0] req,
                                               input logic [FOFF_W-1:0] foff);
    outcome_t    o;
    int unsigned got;
    o.offset = '0;
    o.ok     = 1'b1;
    case (cmd)
      CMD_INIT:  format_heap();
      CMD_ALLOC: begin
        got      = try_alloc(req);
        o.offset = got[PAY_W-1:0];
        o.ok     = (got != 0);
      end
      CMD_FREE:  release_block(foff);
      default:   o.ok = 1'b0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      foreach (tag_store[i]) tag_store[i] = '0;
      size_shadow = HEAP_SIZE_RST;
      format_heap();
      outcome_q.delete();
    end else begin
      if (cfg_we_i) size_shadow = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        outcome_q.push_back(predict_outcome(cmd_e'(s_axis_tuser), s_axis_tdata[14:0],
                                            s_axis_tdata[28:15]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result word, offset", 0, m_axis_tdata[13:0]);
        end else begin
          exp_o = outcome_q.pop_front();
          if (m_axis_tdata[PAY_W-1:0] !== exp_o.offset)
            report_mismatch("payload_offset", exp_o.offset, m_axis_tdata[PAY_W-1:0]);
          if (m_axis_tuser !== exp_o.ok)
            report_mismatch("success", exp_o.ok, m_axis_tuser);
        end
      end
    end
    mismatches_o <= mismatch_total;
    pending_o    <= outcome_q.size();
  end

endmodule

// File: tb/boundary_tag_heap_allocator_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Heap allocator testbench
// Drives init, allocate, free and reserved command words into the allocator
// over a range of heap sizes, with random gaps on the command side and random
// back-pressure on the result side. The checker beside the block predicts and
// compares every result word; this module only makes stimulus and reports.
// -----------------------------------------------------------------------------
module boundary_tag_heap_allocator_tb;
  import bta_pkg::*;

  // Reset sweep plus walks of up to 2048 blocks per word under the
  // longest stalls; several times the slowest possible run.
  localparam int CYCLE_LIMIT = 10_000_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [14:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [14:0] request_size, [28:15] free_offset, rest zero
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [13:0] payload_offset, rest zero
  logic        m_axis_tuser;        // [0] success

  int          mismatches;
  int          pending;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          calm        = 1'b0;  // final stretch: no idling at all
  bit          quiet       = 1'b0;  // per phase: no idling
  int unsigned live_offs [$];       // payload offsets handed out and not yet freed

  boundary_tag_heap_allocator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  boundary_tag_heap_allocator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: drop tready in random bursts outside calm and quiet stretches, hold it high otherwise.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 17);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Collect handed-out offsets so that most frees target real blocks.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && m_axis_tuser && m_axis_tdata[13:0] != 0)
      live_offs.push_back(m_axis_tdata[13:0]);
  end

  // Present one command word and hold it until accepted, then maybe idle.
  task automatic send_word(input cmd_e cmd, input int unsigned req, input int unsigned foff);
    int unsigned gap;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, foff[13:0], req[14:0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lower tvalid and wait until every outstanding result word is back.
  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly allocate/free pairs on live blocks; the rest is noise.
  task automatic random_items(input int unsigned count, input int unsigned span);
    int unsigned k, roll, req, idx, offs;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        roll = $urandom_range(0, 9);
        if (roll < 3)      req = $urandom_range(0, 16);
        else if (roll < 9) req = $urandom_range(0, span / 4);
        else               req = $urandom_range(0, 16384);
        send_word(CMD_ALLOC, req, $urandom_range(0, 16383));
      end else if (roll < 85 && live_offs.size() != 0) begin
        idx  = $urandom_range(0, live_offs.size() - 1);
        offs = live_offs[idx];
        live_offs.delete(idx);
        // now and then knock the low bits, which the block drops
        if ($urandom_range(0, 7) == 0) offs = offs | $urandom_range(1, 3);
        send_word(CMD_FREE, $urandom_range(0, 16384), offs);
      end else if (roll < 93) begin
        send_word(CMD_FREE, $urandom_range(0, 16384), $urandom_range(0, 16383));
      end else if (roll < 96) begin
        send_word(CMD_FREE, $urandom_range(0, 16384), 0);
      end else if (roll < 99) begin
        send_word(CMD_RSVD, $urandom_range(0, 16384), $urandom_range(0, 16383));
      end else begin
        live_offs.delete();
        send_word(CMD_INIT, $urandom_range(0, 16384), $urandom_range(0, 16383));
      end
    end
  endtask

  // Write the heap size while idle, re-format and run a random stretch.
  // With late_init set, a few words run on the old heap first.
  task automatic run_phase(input int unsigned size_val, input int unsigned count,
                           input bit late_init);
    drain();
    quiet = ($urandom_range(0, 3) == 0);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size_val[14:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (late_init) random_items(4, 16384);
    live_offs.delete();
    send_word(CMD_INIT, 0, 0);
    random_items(count, size_val);
  endtask

  initial begin
    // Hold reset, then wait out the store sweep behind tready.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (s_axis_tready !== 1'b1) @(posedge clk_i);

    // Directed words on the heap formatted at reset.
    send_word(CMD_RSVD,  16384, 16383);  // reserved: nothing changes
    send_word(CMD_FREE,  0,     0);      // null free
    send_word(CMD_FREE,  0,     3);      // unaligned, rounds down to null
    send_word(CMD_ALLOC, 0,     0);      // smallest block
    send_word(CMD_ALLOC, 1,     0);      // rounds up to four
    send_word(CMD_ALLOC, 5,     0);
    send_word(CMD_FREE,  0,     12);     // both neighbours used
    send_word(CMD_FREE,  0,     4);      // merge with the next block
    send_word(CMD_FREE,  0,     24);     // merge on both sides
    send_word(CMD_ALLOC, 16384, 0);      // larger than the heap
    send_word(CMD_ALLOC, 16376, 0);      // exact fit of the whole heap
    send_word(CMD_ALLOC, 0,     0);      // heap full, walk runs off the end
    send_word(CMD_FREE,  0,     16383);  // head tag in an empty word
    send_word(CMD_FREE,  0,     6);      // unaligned free of a real block
    send_word(CMD_ALLOC, 16372, 0);      // remainder too small to split
    send_word(CMD_FREE,  0,     5);
    send_word(CMD_ALLOC, 100,   0);
    send_word(CMD_ALLOC, 200,   0);
    send_word(CMD_FREE,  0,     4);
    send_word(CMD_FREE,  0,     4);      // double free
    send_word(CMD_FREE,  0,     8200);   // inside a free region
    send_word(CMD_INIT,  0,     0);
    send_word(CMD_ALLOC, 8,     0);
    send_word(CMD_RSVD,  0,     0);

    // Random stretches over several heap sizes, extremes included.
    run_phase(16,    30, 1'b0);  // smallest heap
    run_phase(18,    25, 1'b0);  // unaligned size, rounds down
    run_phase(256,   70, 1'b1);  // size change before init
    run_phase(1002,  70, 1'b0);
    run_phase(16384, 80, 1'b0);  // whole store
    run_phase(4096,  50, 1'b0);
    calm = 1'b1;
    run_phase(128,   60, 1'b0);

    drain();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
